@@ hw/rtl/clex_pkg.sv @@
// ----------------------------------------------------------------------------
// clex_pkg
// Shared types, codes and character classification for the C-style scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package clex_pkg;

    // default widths and result queue depth
    localparam int LINE_WIDTH_DEF   = 20;
    localparam int COLUMN_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH      = 8;
    localparam int MAX_RESULTS      = 3;

    // scan modes
    localparam logic [4:0] M_START  = 5'd0;
    localparam logic [4:0] M_WS     = 5'd1;
    localparam logic [4:0] M_CMTBEG = 5'd2;
    localparam logic [4:0] M_LCMT   = 5'd3;
    localparam logic [4:0] M_BCMT   = 5'd4;
    localparam logic [4:0] M_BSTAR  = 5'd5;
    localparam logic [4:0] M_HEX0   = 5'd6;
    localparam logic [4:0] M_HEXX   = 5'd7;
    localparam logic [4:0] M_HEXD   = 5'd8;
    localparam logic [4:0] M_DINT   = 5'd9;
    localparam logic [4:0] M_DFRAC  = 5'd10;
    localparam logic [4:0] M_DEXP   = 5'd11;
    localparam logic [4:0] M_DEXPS  = 5'd12;
    localparam logic [4:0] M_DEXPD  = 5'd13;
    localparam logic [4:0] M_STR    = 5'd14;
    localparam logic [4:0] M_ESC    = 5'd15;
    localparam logic [4:0] M_ESCOCT = 5'd16;
    localparam logic [4:0] M_ESCX   = 5'd17;
    localparam logic [4:0] M_ESCXD  = 5'd18;
    localparam logic [4:0] M_NAME   = 5'd19;
    localparam logic [4:0] M_OPEQ   = 5'd20;
    localparam logic [4:0] M_PLUS   = 5'd21;
    localparam logic [4:0] M_MINUS  = 5'd22;
    localparam logic [4:0] M_LT     = 5'd23;
    localparam logic [4:0] M_GT     = 5'd24;
    localparam logic [4:0] M_LT2    = 5'd25;
    localparam logic [4:0] M_GT2    = 5'd26;
    localparam logic [4:0] M_DOT1   = 5'd27;
    localparam logic [4:0] M_DOT2   = 5'd28;
    localparam logic [4:0] M_SLASH  = 5'd29;

    // step outcome codes
    localparam logic [1:0] R_WAIT = 2'd0;
    localparam logic [1:0] R_PART = 2'd1;
    localparam logic [1:0] R_END  = 2'd2;
    localparam logic [1:0] R_BAD  = 2'd3;

    // token end codes
    localparam logic [1:0] X_NO  = 2'd0;
    localparam logic [1:0] X_END = 2'd1;
    localparam logic [1:0] X_BAD = 2'd2;

    // token kinds
    localparam logic [2:0] K_EOF     = 3'd0;
    localparam logic [2:0] K_SPACE   = 3'd1;
    localparam logic [2:0] K_COMMENT = 3'd2;
    localparam logic [2:0] K_INT     = 3'd3;
    localparam logic [2:0] K_FLOAT   = 3'd4;
    localparam logic [2:0] K_STRING  = 3'd5;
    localparam logic [2:0] K_NAME    = 3'd6;
    localparam logic [2:0] K_OP      = 3'd7;

    localparam logic [7:0] CH_NL = 8'h0a;

    // one queued symbol: absent, end of file or a byte
    typedef struct packed {
        logic       unk;
        logic       eof;
        logic [7:0] ch;
    } sym_t;

    localparam sym_t SYM_UNK = '{unk: 1'b1, eof: 1'b0, ch: 8'h00};

    // outcome of offering one symbol to the current token
    typedef struct packed {
        logic [1:0] code;
        logic [4:0] mode;
        logic [1:0] term;
        logic [2:0] kind;
        logic       fl;
        logic [1:0] ed;
    } take_t;

    function automatic logic is_dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_oct(logic [7:0] c);
        return c >= "0" && c <= "7";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_dig(c) || c == "_";
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic bad_tail(logic [7:0] c);
        return is_alpha(c) || c == "_";
    endfunction

    function automatic logic [2:0] kind_of(logic [4:0] m, logic fl);
        logic [2:0] k;
        if (m == M_WS)
            k = K_SPACE;
        else if (m >= M_CMTBEG && m <= M_BSTAR)
            k = K_COMMENT;
        else if (m >= M_HEX0 && m <= M_DEXPD)
            k = fl ? K_FLOAT : K_INT;
        else if (m >= M_STR && m <= M_ESCXD)
            k = K_STRING;
        else if (m == M_NAME)
            k = K_NAME;
        else
            k = K_OP;
        return k;
    endfunction

    // plain string body byte
    function automatic take_t str_step(take_t r_in, sym_t c);
        take_t r;
        r = r_in;
        if (!c.eof && c.ch == "\"")
            r.term = X_END;
        else if (!c.eof && c.ch == "\\")
            r.mode = M_ESC;
        else if (c.eof || c.ch == CH_NL)
            r.code = R_BAD;
        else
            r.mode = M_STR;
        return r;
    endfunction

    // offer symbol c to a token in mode m, n is the symbol after it
    function automatic take_t take(logic [4:0] m, logic fl, logic [1:0] ed,
                                   sym_t c, sym_t n);
        take_t      r;
        logic [7:0] b;
        logic       ok;
        logic       stop;
        logic       nok;
        r.code = R_PART;
        r.mode = m;
        r.term = X_NO;
        r.fl   = fl;
        r.ed   = ed;
        r.kind = kind_of(m, fl);
        b      = c.ch;
        ok     = !c.eof;
        stop   = c.eof || b == CH_NL;
        nok    = !n.eof && !n.unk;
        if (c.unk) begin
            r.code = R_WAIT;
        end else begin
            case (m)
                M_START: begin
                    r.fl   = 1'b0;
                    r.ed   = 2'd0;
                    r.kind = K_OP;
                    if (ok && is_space(b)) begin
                        r.mode = M_WS;
                        r.kind = K_SPACE;
                    end else if (ok && (b == "!" || b == "%" || b == "&" || b == "*"
                                        || b == "^" || b == "|" || b == "=")) begin
                        r.mode = M_OPEQ;
                    end else if (ok && b == "\"") begin
                        r.mode = M_STR;
                        r.kind = K_STRING;
                    end else if (ok && (b == "(" || b == ")" || b == "," || b == ":"
                                        || b == ";" || b == "?" || b == "[" || b == "]"
                                        || b == "{" || b == "}" || b == "~")) begin
                        r.term = X_END;
                    end else if (ok && b == "+") begin
                        r.mode = M_PLUS;
                    end else if (ok && b == "-") begin
                        r.mode = M_MINUS;
                    end else if (ok && b == "<") begin
                        r.mode = M_LT;
                    end else if (ok && b == ">") begin
                        r.mode = M_GT;
                    end else if (ok && (b == "." || b == "/" || b == "0")) begin
                        if (n.unk) begin
                            r.code = R_WAIT;
                        end else if (b == ".") begin
                            if (nok && is_dig(n.ch)) begin
                                r.mode = M_DFRAC;
                                r.fl   = 1'b1;
                                r.kind = K_FLOAT;
                            end else begin
                                r.mode = M_DOT1;
                            end
                        end else if (b == "/") begin
                            if (nok && (n.ch == "*" || n.ch == "/")) begin
                                r.mode = M_CMTBEG;
                                r.kind = K_COMMENT;
                            end else begin
                                r.mode = M_SLASH;
                            end
                        end else begin
                            r.mode = (nok && n.ch == "x") ? M_HEX0 : M_DINT;
                            r.kind = K_INT;
                        end
                    end else if (ok && is_dig(b)) begin
                        r.mode = M_DINT;
                        r.kind = K_INT;
                    end else if (ok && bad_tail(b)) begin
                        r.mode = M_NAME;
                        r.kind = K_NAME;
                    end else begin
                        r.term = X_BAD;
                        r.kind = K_EOF;
                    end
                end
                M_WS: begin
                    if (!(ok && is_space(b)))
                        r.code = R_END;
                end
                M_OPEQ, M_SLASH, M_LT2, M_GT2: begin
                    if (ok && b == "=")
                        r.term = X_END;
                    else
                        r.code = R_END;
                end
                M_DOT2: begin
                    if (ok && b == ".")
                        r.term = X_END;
                    else
                        r.code = R_END;
                end
                M_PLUS, M_MINUS: begin
                    if (ok && (b == "=" || b == ((m == M_PLUS) ? "+" : "-")))
                        r.term = X_END;
                    else
                        r.code = R_END;
                end
                M_LT, M_GT: begin
                    if (ok && b == ((m == M_LT) ? "<" : ">"))
                        r.mode = (m == M_LT) ? M_LT2 : M_GT2;
                    else if (ok && b == "=")
                        r.term = X_END;
                    else
                        r.code = R_END;
                end
                M_DOT1: begin
                    if (!(ok && b == "."))
                        r.code = R_END;
                    else if (n.unk)
                        r.code = R_WAIT;
                    else if (nok && n.ch == ".")
                        r.mode = M_DOT2;
                    else
                        r.code = R_END;
                end
                M_CMTBEG: begin
                    if (ok && b == "*")
                        r.mode = M_BCMT;
                    else if (ok && b == "/")
                        r.mode = M_LCMT;
                    else
                        r.code = R_END;
                end
                M_LCMT: begin
                    if (stop)
                        r.code = R_END;
                end
                M_BCMT, M_BSTAR: begin
                    if (!ok)
                        r.code = R_BAD;
                    else if (b == "*")
                        r.mode = M_BSTAR;
                    else if (b == "/" && m == M_BSTAR)
                        r.term = X_END;
                    else
                        r.mode = M_BCMT;
                end
                M_HEX0: begin
                    if (ok && b == "x")
                        r.mode = M_HEXX;
                    else
                        r.code = R_END;
                end
                M_HEXX, M_ESCX: begin
                    if (ok && is_hex(b))
                        r.mode = (m == M_HEXX) ? M_HEXD : M_ESCXD;
                    else if (stop)
                        r.code = R_BAD;
                    else
                        r.term = X_BAD;
                end
                M_HEXD: begin
                    if (!(ok && is_hex(b))) begin
                        if (ok && bad_tail(b))
                            r.term = X_BAD;
                        else
                            r.code = R_END;
                    end
                end
                M_DINT, M_DFRAC, M_DEXPD: begin
                    if (!(ok && is_dig(b))) begin
                        if (ok && b == "." && m == M_DINT) begin
                            r.mode = M_DFRAC;
                            r.fl   = 1'b1;
                        end else if (ok && (b == "e" || b == "E") && m != M_DEXPD) begin
                            r.mode = M_DEXP;
                            r.fl   = 1'b1;
                        end else if (ok && bad_tail(b)) begin
                            r.term = X_BAD;
                        end else begin
                            r.code = R_END;
                        end
                        r.kind = r.fl ? K_FLOAT : K_INT;
                    end
                end
                M_DEXP, M_DEXPS: begin
                    if (ok && (b == "+" || b == "-") && m == M_DEXP)
                        r.mode = M_DEXPS;
                    else if (ok && is_dig(b))
                        r.mode = M_DEXPD;
                    else if (stop)
                        r.code = R_BAD;
                    else
                        r.term = X_BAD;
                end
                M_STR: begin
                    r = str_step(r, c);
                end
                M_ESC: begin
                    if (ok && (b == "\"" || b == "'" || b == "?" || b == "\\"
                               || b == "a" || b == "b" || b == "f" || b == "n"
                               || b == "r" || b == "t" || b == "v")) begin
                        r.mode = M_STR;
                    end else if (ok && is_oct(b)) begin
                        r.mode = M_ESCOCT;
                        r.ed   = 2'd1;
                    end else if (ok && b == "x") begin
                        r.mode = M_ESCX;
                    end else if (stop) begin
                        r.code = R_BAD;
                    end else begin
                        r.term = X_BAD;
                    end
                end
                M_ESCOCT: begin
                    if (ok && is_oct(b) && ed != 2'd3) begin
                        if (ed >= 2'd2) begin
                            r.mode = M_STR;
                            r.ed   = 2'd0;
                        end else begin
                            r.ed = ed + 2'd1;
                        end
                    end else begin
                        r.ed = 2'd0;
                        r    = str_step(r, c);
                    end
                end
                M_ESCXD: begin
                    if (ok && is_hex(b))
                        r.mode = M_STR;
                    else
                        r = str_step(r, c);
                end
                M_NAME: begin
                    if (!(ok && is_word(b)))
                        r.code = R_END;
                end
                default: begin
                    r.code = R_END;
                end
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/clex_in_if.sv @@
// ----------------------------------------------------------------------------
// clex_in_if
// Source byte channel: one byte or end-of-file mark per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface clex_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       end_of_input;

    modport source (output valid, output character, output end_of_input, input ready);
    modport sink   (input valid, input character, input end_of_input, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/clex_out_if.sv @@
// ----------------------------------------------------------------------------
// clex_out_if
// Token byte channel: one classified byte with its position per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface clex_out_if #(
    parameter int LINE_WIDTH   = clex_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = clex_pkg::COLUMN_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [7:0]              out_char;
    logic [2:0]              token_kind;
    logic                    token_first;
    logic                    token_last;
    logic                    illegal;
    logic [LINE_WIDTH-1:0]   line_no;
    logic [COLUMN_WIDTH-1:0] column_no;

    modport source (output valid, output out_char, output token_kind, output token_first,
                    output token_last, output illegal, output line_no, output column_no,
                    input ready);
    modport sink   (input valid, input out_char, input token_kind, input token_first,
                    input token_last, input illegal, input line_no, input column_no,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/clex_scan.sv @@
// ----------------------------------------------------------------------------
// clex_scan
// Scanner state and single-pass step: classifies held bytes plus the new one.
// ----------------------------------------------------------------------------
`default_nettype none

module clex_scan #(
    parameter int LINE_WIDTH   = clex_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = clex_pkg::COLUMN_WIDTH_DEF,
    localparam int RES_W       = 14 + LINE_WIDTH + COLUMN_WIDTH
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      fire,
    input  wire logic [7:0]                                in_char,
    input  wire logic                                      in_eoi,
    output logic      [1:0]                                push_cnt,
    output logic      [clex_pkg::MAX_RESULTS-1:0][RES_W-1:0] push_data
);

    typedef struct packed {
        logic [7:0]              out_char;
        logic [2:0]              token_kind;
        logic                    token_first;
        logic                    token_last;
        logic                    illegal;
        logic [LINE_WIDTH-1:0]   line_no;
        logic [COLUMN_WIDTH-1:0] column_no;
    } res_t;

    // scanner state
    logic [4:0]              mode_reg, mode_next;
    logic                    fl_reg, fl_next;
    logic [1:0]              ed_reg, ed_next;
    logic                    halt_reg, halt_next;
    logic [1:0]              held_count_reg, held_count_next;
    logic [7:0]              held_char_reg [2];
    logic [7:0]              held_char_next [2];
    logic [LINE_WIDTH-1:0]   held_line_reg [2];
    logic [LINE_WIDTH-1:0]   held_line_next [2];
    logic [COLUMN_WIDTH-1:0] held_col_reg [2];
    logic [COLUMN_WIDTH-1:0] held_col_next [2];
    logic [LINE_WIDTH-1:0]   line_reg, line_next;
    logic [COLUMN_WIDTH-1:0] col_reg, col_next;

    res_t res [clex_pkg::MAX_RESULTS];

    // step over the queue of held bytes and the new symbol
    always_comb
    begin
        clex_pkg::sym_t          q [3];
        logic [LINE_WIDTH-1:0]   qln [3];
        logic [COLUMN_WIDTH-1:0] qcl [3];
        clex_pkg::sym_t          c1, c2, c3;
        clex_pkg::take_t         a, b;
        logic [4:0]              mode_v;
        logic                    fl_v;
        logic [1:0]              ed_v;
        logic                    halt_v;
        logic                    stop_v;
        logic                    eof_hit;
        logic                    hold_v;
        logic [1:0]              hold_idx;
        logic [1:0]              n_v;
        logic                    last_v;
        logic                    bad_v;
        logic                    wait_b;

        // build the queue
        for (int i = 0; i < 3; i++) begin
            if (i < int'(held_count_reg)) begin
                q[i]   = '{unk: 1'b0, eof: 1'b0, ch: held_char_reg[i[0]]};
                qln[i] = held_line_reg[i[0]];
                qcl[i] = held_col_reg[i[0]];
            end else if (i == int'(held_count_reg)) begin
                q[i]   = '{unk: 1'b0, eof: in_eoi, ch: in_char};
                qln[i] = line_reg;
                qcl[i] = col_reg;
            end else begin
                q[i]   = clex_pkg::SYM_UNK;
                qln[i] = line_reg;
                qcl[i] = col_reg;
            end
        end

        mode_v   = mode_reg;
        fl_v     = fl_reg;
        ed_v     = ed_reg;
        halt_v   = halt_reg;
        stop_v   = 1'b0;
        eof_hit  = 1'b0;
        hold_v   = 1'b0;
        hold_idx = 2'd0;
        n_v      = 2'd0;
        a        = '0;
        b        = '0;
        last_v   = 1'b0;
        bad_v    = 1'b0;
        wait_b   = 1'b0;
        for (int k = 0; k < clex_pkg::MAX_RESULTS; k++)
            res[k] = '0;

        // one pass per queue slot
        for (int i = 0; i < 3; i++) begin
            c1 = q[i];
            c2 = clex_pkg::SYM_UNK;
            c3 = clex_pkg::SYM_UNK;
            if (i < 2)
                c2 = q[i+1];
            if (i < 1)
                c3 = q[i+2];
            if (!stop_v && !c1.unk) begin
                if (c1.eof) begin
                    res[n_v] = '{out_char: 8'h00, token_kind: clex_pkg::K_EOF,
                                 token_first: 1'b1, token_last: 1'b1, illegal: 1'b0,
                                 line_no: line_reg, column_no: col_reg};
                    n_v      = n_v + 2'd1;
                    eof_hit  = 1'b1;
                    stop_v   = 1'b1;
                end else if (!halt_v) begin
                    a = clex_pkg::take(mode_v, fl_v, ed_v, c1, c2);
                    // token ended before this byte: restart from token start
                    if (a.code == clex_pkg::R_END || a.code == clex_pkg::R_BAD) begin
                        mode_v = clex_pkg::M_START;
                        fl_v   = 1'b0;
                        ed_v   = 2'd0;
                        a      = clex_pkg::take(clex_pkg::M_START, 1'b0, 2'd0, c1, c2);
                    end
                    if (a.code == clex_pkg::R_WAIT) begin
                        stop_v   = 1'b1;
                        hold_v   = 1'b1;
                        hold_idx = 2'(i);
                    end else begin
                        last_v = 1'b0;
                        bad_v  = 1'b0;
                        wait_b = 1'b0;
                        if (a.term == clex_pkg::X_END) begin
                            last_v = 1'b1;
                        end else if (a.term == clex_pkg::X_BAD) begin
                            last_v = 1'b1;
                            bad_v  = 1'b1;
                        end else begin
                            // look one byte ahead to see whether the token ends here
                            b = clex_pkg::take(a.mode, a.fl, a.ed, c2, c3);
                            if (b.code == clex_pkg::R_WAIT) begin
                                wait_b = 1'b1;
                            end else if (b.code == clex_pkg::R_END) begin
                                last_v = 1'b1;
                            end else if (b.code == clex_pkg::R_BAD) begin
                                last_v = 1'b1;
                                bad_v  = 1'b1;
                            end
                        end
                        if (wait_b) begin
                            stop_v   = 1'b1;
                            hold_v   = 1'b1;
                            hold_idx = 2'(i);
                        end else begin
                            res[n_v] = '{out_char: c1.ch, token_kind: a.kind,
                                         token_first: mode_v == clex_pkg::M_START,
                                         token_last: last_v, illegal: bad_v,
                                         line_no: qln[i], column_no: qcl[i]};
                            n_v      = n_v + 2'd1;
                            if (last_v) begin
                                mode_v = clex_pkg::M_START;
                                fl_v   = 1'b0;
                                ed_v   = 2'd0;
                                if (bad_v)
                                    halt_v = 1'b1;
                            end else begin
                                mode_v = a.mode;
                                fl_v   = a.fl;
                                ed_v   = a.ed;
                            end
                        end
                    end
                end
            end
        end

        // defaults hold state
        mode_next       = mode_reg;
        fl_next         = fl_reg;
        ed_next         = ed_reg;
        halt_next       = halt_reg;
        held_count_next = held_count_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        for (int k = 0; k < 2; k++) begin
            held_char_next[k] = held_char_reg[k];
            held_line_next[k] = held_line_reg[k];
            held_col_next[k]  = held_col_reg[k];
        end
        push_cnt = 2'd0;

        if (fire && !(halt_reg && !in_eoi)) begin
            push_cnt = n_v;
            if (eof_hit) begin
                mode_next       = clex_pkg::M_START;
                fl_next         = 1'b0;
                ed_next         = 2'd0;
                halt_next       = 1'b0;
                held_count_next = 2'd0;
                line_next       = LINE_WIDTH'(1);
                col_next        = COLUMN_WIDTH'(1);
            end else begin
                mode_next = mode_v;
                fl_next   = fl_v;
                ed_next   = ed_v;
                halt_next = halt_v;
                // position of the next byte, saturating
                if (in_char == clex_pkg::CH_NL) begin
                    if (line_reg != {LINE_WIDTH{1'b1}})
                        line_next = line_reg + LINE_WIDTH'(1);
                    col_next = COLUMN_WIDTH'(1);
                end else if (col_reg != {COLUMN_WIDTH{1'b1}}) begin
                    col_next = col_reg + COLUMN_WIDTH'(1);
                end
                // keep the bytes still waiting for lookahead
                held_count_next = 2'd0;
                if (hold_v) begin
                    case (hold_idx)
                        2'd0: begin
                            held_char_next[0] = q[0].ch;
                            held_line_next[0] = qln[0];
                            held_col_next[0]  = qcl[0];
                            held_char_next[1] = q[1].ch;
                            held_line_next[1] = qln[1];
                            held_col_next[1]  = qcl[1];
                            held_count_next   = q[1].unk ? 2'd1 : 2'd2;
                        end
                        2'd1: begin
                            held_char_next[0] = q[1].ch;
                            held_line_next[0] = qln[1];
                            held_col_next[0]  = qcl[1];
                            held_char_next[1] = q[2].ch;
                            held_line_next[1] = qln[2];
                            held_col_next[1]  = qcl[2];
                            held_count_next   = q[2].unk ? 2'd1 : 2'd2;
                        end
                        default: begin
                            held_char_next[0] = q[2].ch;
                            held_line_next[0] = qln[2];
                            held_col_next[0]  = qcl[2];
                            held_count_next   = 2'd1;
                        end
                    endcase
                end
            end
        end
    end

    // pack results for the queue
    always_comb
    begin
        for (int k = 0; k < clex_pkg::MAX_RESULTS; k++)
            push_data[k] = res[k];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= clex_pkg::M_START;
            fl_reg         <= 1'b0;
            ed_reg         <= 2'd0;
            halt_reg       <= 1'b0;
            held_count_reg <= 2'd0;
            line_reg       <= LINE_WIDTH'(1);
            col_reg        <= COLUMN_WIDTH'(1);
        end else begin
            mode_reg       <= mode_next;
            fl_reg         <= fl_next;
            ed_reg         <= ed_next;
            halt_reg       <= halt_next;
            held_count_reg <= held_count_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
        end
    end

    // held bytes and their positions
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++) begin
            held_char_reg[k] <= held_char_next[k];
            held_line_reg[k] <= held_line_next[k];
            held_col_reg[k]  <= held_col_next[k];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/clex_fifo.sv @@
// ----------------------------------------------------------------------------
// clex_fifo
// Result queue: takes up to three results a cycle, gives one per request.
// ----------------------------------------------------------------------------
`default_nettype none

module clex_fifo #(
    parameter int WIDTH  = 50,
    parameter int DEPTH  = clex_pkg::QUEUE_DEPTH,
    localparam int PW    = $clog2(DEPTH),
    localparam int LW    = $clog2(DEPTH + 1)
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic [1:0]                                push_cnt,
    input  wire logic [clex_pkg::MAX_RESULTS-1:0][WIDTH-1:0] push_data,
    output logic                                           room,
    output logic                                           rd_valid,
    input  wire logic                                      rd_ready,
    output logic      [WIDTH-1:0]                          rd_data,
    output logic      [LW-1:0]                             level
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    count_reg, count_next;
    logic             pop;

    assign level    = count_reg;
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign room     = count_reg <= LW'(DEPTH - clex_pkg::MAX_RESULTS);
    assign pop      = rd_valid && rd_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + LW'(push_cnt) - LW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage writes
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < clex_pkg::MAX_RESULTS; k++) begin
            if (k < int'(push_cnt))
                mem[wr_ptr_reg + PW'(k)] <= push_data[k];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/c_like_lexer.sv @@
// ----------------------------------------------------------------------------
// c_like_lexer
// C-style lexical scanner: classifies a byte stream into tokens with positions.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  feed     | in  | character, end_of_input
//  result   | out | out_char, token_kind, token_first, token_last, illegal,
//           |     | line_no, column_no
//
// One byte is taken per cycle; each yields zero to three results, drained
// one per cycle from an eight-entry result queue.
// feed.ready drops while the queue has fewer than three free entries.
// Reset puts the scanner at token start, line 1, column 1, queue empty.
// A stall on result only fills the queue; scanner state moves on accept only.
// ----------------------------------------------------------------------------
`default_nettype none

module c_like_lexer #(
    parameter int LINE_WIDTH   = clex_pkg::LINE_WIDTH_DEF,
    parameter int COLUMN_WIDTH = clex_pkg::COLUMN_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    clex_in_if.sink   feed,
    clex_out_if.source result
);

    localparam int RES_W = 14 + LINE_WIDTH + COLUMN_WIDTH;
    localparam int LVL_W = $clog2(clex_pkg::QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]              out_char;
        logic [2:0]              token_kind;
        logic                    token_first;
        logic                    token_last;
        logic                    illegal;
        logic [LINE_WIDTH-1:0]   line_no;
        logic [COLUMN_WIDTH-1:0] column_no;
    } res_t;

    logic                                          fire;
    logic                                          room;
    logic [1:0]                                    push_cnt;
    logic [clex_pkg::MAX_RESULTS-1:0][RES_W-1:0]   push_data;
    logic [RES_W-1:0]                              rd_data;
    logic [LVL_W-1:0]                              level;
    res_t                                          head;

    assign feed.ready = room;
    assign fire       = feed.valid && room;

    // classification step
    clex_scan #(
        .LINE_WIDTH   (LINE_WIDTH),
        .COLUMN_WIDTH (COLUMN_WIDTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_char   (feed.character),
        .in_eoi    (feed.end_of_input),
        .push_cnt  (push_cnt),
        .push_data (push_data)
    );

    // result queue
    clex_fifo #(
        .WIDTH (RES_W),
        .DEPTH (clex_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .room      (room),
        .rd_valid  (result.valid),
        .rd_ready  (result.ready),
        .rd_data   (rd_data),
        .level     (level)
    );

    // unpack head of queue onto the result channel
    assign head               = rd_data;
    assign result.out_char    = head.out_char;
    assign result.token_kind  = head.token_kind;
    assign result.token_first = head.token_first;
    assign result.token_last  = head.token_last;
    assign result.illegal     = head.illegal;
    assign result.line_no     = head.line_no;
    assign result.column_no   = head.column_no;

    // results are only produced by an accepted request
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |-> fire)
        else $error("results pushed without an accepted request");

    // end of input always yields at least the eof marker
    a_eof_marker: assert property (@(posedge clk) disable iff (!rst_n)
        fire && feed.end_of_input |-> push_cnt != 2'd0)
        else $error("end of input produced no result");

    // queue never overfills
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LVL_W'(clex_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

endmodule

`default_nettype wire
